[rtl/i2c_motor_register_controller_unit_assert.svh]
// Assertion macros used by the controller RTL.
`ifndef I2C_MOTOR_REGISTER_CONTROLLER_UNIT_ASSERT_SVH
`define I2C_MOTOR_REGISTER_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define IMRC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("controller assertion failed");
// checked on every edge, reset included
`define IMRC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("controller assertion failed");
`else
`define IMRC_ASSERT(lbl, clk, rst_n, prop)
`define IMRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/imrc_pkg.sv]
`timescale 1ns / 1ps
package imrc_pkg;

	localparam int REG_COUNT = 16;
	localparam int PTR_W     = $clog2(REG_COUNT);
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// request types
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// bus phases
	localparam logic [1:0] PHASE_IDLE    = 2'd0;
	localparam logic [1:0] PHASE_CONTROL = 2'd1;
	localparam logic [1:0] PHASE_DATA    = 2'd2;

	// fixed register slots
	localparam logic [PTR_W-1:0] REG_DIR     = PTR_W'(0);
	localparam logic [PTR_W-1:0] REG_DUTY_LO = PTR_W'(1);
	localparam logic [PTR_W-1:0] REG_DUTY_HI = PTR_W'(2);
	localparam logic [PTR_W-1:0] REG_TGT_LO  = PTR_W'(3);
	localparam logic [PTR_W-1:0] REG_TGT_HI  = PTR_W'(4);
	localparam logic [PTR_W-1:0] REG_FLAG    = PTR_W'(5);

	localparam logic [7:0] DUTY_LO_RST = 8'hff;
	localparam logic [7:0] DUTY_HI_RST = 8'h01;
	localparam logic [7:0] DIR_MAX     = 8'h03;

	// configuration register indexes
	localparam logic [1:0] CFG_GO    = 2'd0;
	localparam logic [1:0] CFG_BREAK = 2'd1;
	localparam logic [1:0] CFG_DONE  = 2'd2;

	localparam logic [7:0] GO_RST    = 8'h01;
	localparam logic [7:0] BREAK_RST = 8'h02;
	localparam logic [7:0] DONE_RST  = 8'h03;

	typedef struct packed {
		logic [7:0] go_code;
		logic [7:0] break_code;
		logic [7:0] done_code;
	} cfg_t;

	typedef struct packed {
		logic        read_valid;
		logic [7:0]  read_data;
		logic        bridge_pin_a;
		logic        bridge_pin_b;
		logic [15:0] pwm_duty;
		logic        move_active;
	} res_t;

endpackage

[rtl/imrc_cfg.sv]
`timescale 1ns / 1ps
module imrc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [imrc_pkg::PADDR_W-1:0] paddr,
	input  logic [imrc_pkg::PDATA_W-1:0] pwdata,
	output logic [imrc_pkg::PDATA_W-1:0] prdata,
	output imrc_pkg::cfg_t              cfg
);

	logic [1:0] idx;
	logic       wr;
	logic [7:0] go_q, break_q, done_q;
	logic [7:0] rd;

	assign idx = paddr[3:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q    <= imrc_pkg::GO_RST;
			break_q <= imrc_pkg::BREAK_RST;
			done_q  <= imrc_pkg::DONE_RST;
		end else if (wr) begin
			case (idx)
				imrc_pkg::CFG_GO:    go_q    <= pwdata[7:0];
				imrc_pkg::CFG_BREAK: break_q <= pwdata[7:0];
				imrc_pkg::CFG_DONE:  done_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			imrc_pkg::CFG_GO:    rd = go_q;
			imrc_pkg::CFG_BREAK: rd = break_q;
			imrc_pkg::CFG_DONE:  rd = done_q;
			default:             rd = 8'h00;
		endcase
	end

	assign prdata           = {{(imrc_pkg::PDATA_W-8){1'b0}}, rd};
	assign cfg.go_code      = go_q;
	assign cfg.break_code   = break_q;
	assign cfg.done_code    = done_q;

endmodule

[rtl/imrc_core.sv]
`timescale 1ns / 1ps
module imrc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [1:0]      req_type,
	input  logic [7:0]      bus_byte,
	input  logic            encoder_level,
	input  imrc_pkg::cfg_t  cfg,
	output imrc_pkg::res_t  res
);

	logic [7:0]                 reg_q [imrc_pkg::REG_COUNT];
	logic [7:0]                 reg_n [imrc_pkg::REG_COUNT];
	logic [1:0]                 phase_q, phase_n;
	logic [imrc_pkg::PTR_W-1:0] ptr_q, ptr_n;
	logic                       pin_a_q, pin_b_q, pin_a_n, pin_b_n;
	logic                       counting_q, counting_n;
	logic [15:0]                edge_q, edge_n;
	logic [15:0]                target_q, target_n;
	logic                       last_q, last_n;
	logic                       bus_wr;
	logic                       finish;
	logic [15:0]                edge_inc;
	logic [15:0]                tgt_regs;
	logic [7:0]                 dir;

	assign dir      = reg_q[imrc_pkg::REG_DIR];
	assign edge_inc = edge_q + 16'd1;
	assign tgt_regs = {reg_q[imrc_pkg::REG_TGT_HI], reg_q[imrc_pkg::REG_TGT_LO]};

	always_comb begin
		phase_n    = phase_q;
		ptr_n      = ptr_q;
		pin_a_n    = pin_a_q;
		pin_b_n    = pin_b_q;
		counting_n = counting_q;
		edge_n     = edge_q;
		target_n   = target_q;
		last_n     = last_q;
		bus_wr     = 1'b0;
		finish     = 1'b0;
		res.read_valid = 1'b0;
		res.read_data  = 8'h00;
		case (req_type)
			imrc_pkg::REQ_BYTE: begin
				case (phase_q)
					imrc_pkg::PHASE_CONTROL: begin
						ptr_n   = bus_byte[imrc_pkg::PTR_W-1:0];
						phase_n = imrc_pkg::PHASE_DATA;
					end
					imrc_pkg::PHASE_DATA: begin
						bus_wr  = 1'b1;
						phase_n = imrc_pkg::PHASE_IDLE;
					end
					default: phase_n = imrc_pkg::PHASE_CONTROL;
				endcase
			end
			imrc_pkg::REQ_READ: begin
				if (phase_q == imrc_pkg::PHASE_DATA) begin
					res.read_valid = 1'b1;
					res.read_data  = reg_q[ptr_q];
					phase_n        = imrc_pkg::PHASE_IDLE;
				end
			end
			imrc_pkg::REQ_TICK: begin
				// codes above 3 hold the pins
				if (dir <= imrc_pkg::DIR_MAX) begin
					pin_a_n = dir[1];
					pin_b_n = dir[0];
				end
				if (!counting_q) begin
					if (reg_q[imrc_pkg::REG_FLAG] == cfg.go_code) begin
						target_n   = tgt_regs;
						edge_n     = 16'd0;
						last_n     = encoder_level;
						counting_n = 1'b1;
						finish     = (tgt_regs == 16'd0);
					end
				end else if (reg_q[imrc_pkg::REG_FLAG] == cfg.break_code) begin
					finish = 1'b1;
				end else if (encoder_level != last_q) begin
					last_n = encoder_level;
					edge_n = edge_inc;
					finish = (edge_inc >= target_q);
				end
			end
			default: ;
		endcase
		if (finish) counting_n = 1'b0;

		for (int i = 0; i < imrc_pkg::REG_COUNT; i++) begin
			reg_n[i] = reg_q[i];
			if (bus_wr && ptr_q == imrc_pkg::PTR_W'(i)) reg_n[i] = bus_byte;
		end
		if (finish) begin
			reg_n[imrc_pkg::REG_TGT_LO] = 8'h00;
			reg_n[imrc_pkg::REG_TGT_HI] = 8'h00;
			reg_n[imrc_pkg::REG_FLAG]   = cfg.done_code;
		end

		res.bridge_pin_a = pin_a_n;
		res.bridge_pin_b = pin_b_n;
		res.pwm_duty     = {reg_n[imrc_pkg::REG_DUTY_HI], reg_n[imrc_pkg::REG_DUTY_LO]};
		res.move_active  = counting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imrc_pkg::REG_COUNT; i++) begin
				reg_q[i] <= 8'h00;
			end
			reg_q[imrc_pkg::REG_DUTY_LO] <= imrc_pkg::DUTY_LO_RST;
			reg_q[imrc_pkg::REG_DUTY_HI] <= imrc_pkg::DUTY_HI_RST;
			phase_q    <= imrc_pkg::PHASE_IDLE;
			ptr_q      <= '0;
			pin_a_q    <= 1'b0;
			pin_b_q    <= 1'b0;
			counting_q <= 1'b0;
			edge_q     <= 16'd0;
			target_q   <= 16'd0;
			last_q     <= 1'b0;
		end else if (step) begin
			for (int i = 0; i < imrc_pkg::REG_COUNT; i++) begin
				reg_q[i] <= reg_n[i];
			end
			phase_q    <= phase_n;
			ptr_q      <= ptr_n;
			pin_a_q    <= pin_a_n;
			pin_b_q    <= pin_b_n;
			counting_q <= counting_n;
			edge_q     <= edge_n;
			target_q   <= target_n;
			last_q     <= last_n;
		end
	end

endmodule

[rtl/i2c_motor_register_controller_unit.sv]
`timescale 1ns / 1ps
// Motor controller slave: takes one request per clock while in_stall is low
// (bus byte, bus read or timer tick) and returns one result per request,
// presented through a request register, then the register-file update and
// the result register. Full throughput is held as long as out_stall stays
// low; a stalled result backs up into the request register and then raises
// in_stall. The 16-byte register file, bus pointer and move counters all
// update on the same clock edge that loads the result register. go, break
// and done codes sit at APB byte addresses 0x0, 0x4 and 0x8 and should be
// written only while idle.
module i2c_motor_register_controller_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [imrc_pkg::PADDR_W-1:0] paddr,
	input  logic [imrc_pkg::PDATA_W-1:0] pwdata,
	output logic [imrc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic [7:0]                   bus_byte,
	input  logic                         encoder_level,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         read_valid,
	output logic [7:0]                   read_data,
	output logic                         bridge_pin_a,
	output logic                         bridge_pin_b,
	output logic [15:0]                  pwm_duty,
	output logic                         move_active
);

`include "i2c_motor_register_controller_unit_assert.svh"

	imrc_pkg::cfg_t cfg;
	imrc_pkg::res_t res_next;
	imrc_pkg::res_t res_q;
	logic           valid_s1;
	logic [1:0]     req_type_s1;
	logic [7:0]     bus_byte_s1;
	logic           encoder_level_s1;
	logic           out_valid_q;
	logic           adv;
	logic           step;

	assign pready   = 1'b1;
	assign adv      = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	imrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	imrc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.req_type      (req_type_s1),
		.bus_byte      (bus_byte_s1),
		.encoder_level (encoder_level_s1),
		.cfg           (cfg),
		.res           (res_next)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1      <= req_type;
			bus_byte_s1      <= bus_byte;
			encoder_level_s1 <= encoder_level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_valid   = res_q.read_valid;
	assign read_data    = res_q.read_data;
	assign bridge_pin_a = res_q.bridge_pin_a;
	assign bridge_pin_b = res_q.bridge_pin_b;
	assign pwm_duty     = res_q.pwm_duty;
	assign move_active  = res_q.move_active;

	`IMRC_ASSERT(a_rdata_zero, clk, arst_n, (out_valid && !read_valid) |-> (read_data == 8'h00))
	`IMRC_ASSERT(a_s1_hold, clk, arst_n, in_stall |=> (valid_s1 && $stable(req_type_s1) && $stable(bus_byte_s1)))
	`IMRC_ASSERT(a_out_src, clk, arst_n, $rose(out_valid) |-> $past(valid_s1))
	`IMRC_ASSERT_ALWAYS(a_no_stall_empty, clk, in_stall |-> (valid_s1 && out_valid_q))

endmodule
